// ===== rtl/c16ex_pkg.sv =====
// Package for the 16-bit CPU execute stage: opcodes, pipeline word types and divider step.
package c16ex_pkg;

  localparam int DIV_BITS = 32;
  localparam int MOD_STEP = 16;

  typedef logic [4:0] opcode_t;

  localparam opcode_t OP_SET = 5'h01;
  localparam opcode_t OP_ADD = 5'h02;
  localparam opcode_t OP_SUB = 5'h03;
  localparam opcode_t OP_MUL = 5'h04;
  localparam opcode_t OP_MLI = 5'h05;
  localparam opcode_t OP_DIV = 5'h06;
  localparam opcode_t OP_DVI = 5'h07;
  localparam opcode_t OP_MOD = 5'h08;
  localparam opcode_t OP_MDI = 5'h09;
  localparam opcode_t OP_AND = 5'h0a;
  localparam opcode_t OP_BOR = 5'h0b;
  localparam opcode_t OP_XOR = 5'h0c;
  localparam opcode_t OP_SHR = 5'h0d;
  localparam opcode_t OP_ASR = 5'h0e;
  localparam opcode_t OP_SHL = 5'h0f;
  localparam opcode_t OP_IFB = 5'h10;
  localparam opcode_t OP_IFC = 5'h11;
  localparam opcode_t OP_IFE = 5'h12;
  localparam opcode_t OP_IFN = 5'h13;
  localparam opcode_t OP_IFG = 5'h14;
  localparam opcode_t OP_IFA = 5'h15;
  localparam opcode_t OP_IFL = 5'h16;
  localparam opcode_t OP_IFU = 5'h17;
  localparam opcode_t OP_ADX = 5'h1a;
  localparam opcode_t OP_SBX = 5'h1b;
  localparam opcode_t OP_STI = 5'h1e;
  localparam opcode_t OP_STD = 5'h1f;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_INC  = 2'b01;
  localparam logic [1:0] STEP_DEC  = 2'b11;

  typedef struct packed {
    opcode_t     kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] ex;
  } front_t;

  typedef struct packed {
    opcode_t     kind;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] ex;
    logic [31:0] prod;
  } mul_t;

  typedef struct packed {
    opcode_t     kind;
    logic [15:0] res;
    logic [15:0] exo;
    logic        wb;
    logic        skip;
    logic [1:0]  step;
    logic [15:0] rem;
    logic [15:0] dvs;
    logic [15:0] modr;
    logic [31:0] dq;
    logic        neg_q;
    logic        neg_r;
    logic        div0;
  } divw_t;

  typedef struct packed {
    logic [15:0] res;
    logic [15:0] exo;
    logic        wb;
    logic        skip;
    logic [1:0]  step;
  } res_t;

  function automatic divw_t div_step(divw_t w);
    logic [16:0] trial;
    logic [17:0] diff;
    divw_t       n;
    n     = w;
    trial = {w.rem, w.dq[31]};
    diff  = {1'b0, trial} - {2'b00, w.dvs};
    if (!diff[17]) begin
      n.rem = diff[15:0];
    end else begin
      n.rem = trial[15:0];
    end
    n.dq = {w.dq[30:0], ~diff[17]};
    return n;
  endfunction

endpackage

// ===== rtl/cpu16_basic_op_execute.sv =====
// Pipelined execute stage for the two-operand opcodes of a 16-bit CPU.
//
// Channel  Direction  Contents of tdata (lowest bit first)
// s_axis   in         kind[4:0], a_value[15:0], b_value[15:0], overflow_in[15:0], pad
// m_axis   out        result[15:0], overflow_out[15:0], write_back, skip_next,
//                     index_step[1:0], pad
//
// One word is taken every cycle while the skid register is empty.
// The depth is set by the restoring divider, which resolves one quotient bit per stage.
// Reset clears the valid bits of every stage, the output register and the skid register.
// When the output stalls as a word leaves the divider, that word is caught in the skid register and the pipe freezes.
module cpu16_basic_op_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // kind, a_value, b_value, overflow_in, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result, overflow_out, write_back, skip_next, index_step, pad
);
  import c16ex_pkg::*;

  logic        en;
  logic        v1;
  front_t      r1;
  logic        v2;
  mul_t        r2;
  logic        vd   [0:DIV_BITS];
  divw_t       dstg [0:DIV_BITS];
  divw_t       dnext[1:DIV_BITS];
  divw_t       setup;
  res_t        fin;
  res_t        obuf;
  logic        ovalid;
  res_t        skid;
  logic        skid_valid;
  logic        o_free;
  logic [16:0] ma;
  logic [16:0] mb;
  logic [33:0] prod_full;
  logic [16:0] add17;
  logic [31:0] wide;
  logic [4:0]  asr_cnt;
  logic [15:0] abs_a;
  logic [15:0] abs_b;

  assign en       = ~skid_valid;
  assign s_tready = en;
  assign o_free   = ~ovalid | m_tready;

  // Front register and multiplier stage.
  assign ma        = {(r1.kind == OP_MLI) & r1.a[15], r1.a};
  assign mb        = {(r1.kind == OP_MLI) & r1.b[15], r1.b};
  assign prod_full = $signed(ma) * $signed(mb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
    if (en) begin
      r1.kind <= s_tdata[4:0];
      r1.a    <= s_tdata[20:5];
      r1.b    <= s_tdata[36:21];
      r1.ex   <= s_tdata[52:37];
      r2.kind <= r1.kind;
      r2.a    <= r1.a;
      r2.b    <= r1.b;
      r2.ex   <= r1.ex;
      r2.prod <= prod_full[31:0];
    end
  end

  // Non-divide operations and divider set-up.
  assign abs_a = r2.a[15] ? 16'(-r2.a) : r2.a;
  assign abs_b = r2.b[15] ? 16'(-r2.b) : r2.b;

  always_comb begin
    add17   = 17'b0;
    wide    = 32'b0;
    asr_cnt = 5'd0;
    setup       = '0;
    setup.kind  = r2.kind;
    setup.exo   = r2.ex;
    setup.step  = STEP_NONE;
    unique case (r2.kind)
      OP_SET: begin
        setup.res = r2.a;
        setup.wb  = 1'b1;
      end
      OP_STI: begin
        setup.res  = r2.a;
        setup.wb   = 1'b1;
        setup.step = STEP_INC;
      end
      OP_STD: begin
        setup.res  = r2.a;
        setup.wb   = 1'b1;
        setup.step = STEP_DEC;
      end
      OP_ADD: begin
        add17     = {1'b0, r2.b} + {1'b0, r2.a};
        setup.res = add17[15:0];
        setup.exo = {15'b0, add17[16]};
        setup.wb  = 1'b1;
      end
      OP_SUB: begin
        setup.res = r2.b - r2.a;
        setup.exo = (r2.b < r2.a) ? 16'hffff : 16'h0000;
        setup.wb  = 1'b1;
      end
      OP_MUL, OP_MLI: begin
        setup.res = r2.prod[15:0];
        setup.exo = r2.prod[31:16];
        setup.wb  = 1'b1;
      end
      OP_DIV, OP_MOD: begin
        setup.wb   = 1'b1;
        setup.dvs  = r2.a;
        setup.dq   = {r2.b, 16'h0000};
        setup.div0 = (r2.a == 16'h0000);
      end
      OP_DVI, OP_MDI: begin
        setup.wb    = 1'b1;
        setup.dvs   = abs_a;
        setup.dq    = {abs_b, 16'h0000};
        setup.neg_q = r2.a[15] ^ r2.b[15];
        setup.neg_r = r2.b[15];
        setup.div0  = (r2.a == 16'h0000);
      end
      OP_AND: begin
        setup.res = r2.b & r2.a;
        setup.wb  = 1'b1;
      end
      OP_BOR: begin
        setup.res = r2.b | r2.a;
        setup.wb  = 1'b1;
      end
      OP_XOR: begin
        setup.res = r2.b ^ r2.a;
        setup.wb  = 1'b1;
      end
      OP_SHR: begin
        wide      = (r2.a < 16'd32) ? ({r2.b, 16'h0000} >> r2.a[4:0]) : 32'b0;
        setup.res = wide[31:16];
        setup.exo = wide[15:0];
        setup.wb  = 1'b1;
      end
      OP_ASR: begin
        asr_cnt   = (r2.a < 16'd31) ? r2.a[4:0] : 5'd31;
        wide      = $signed({r2.b, 16'h0000}) >>> asr_cnt;
        setup.res = wide[31:16];
        setup.exo = wide[15:0];
        setup.wb  = 1'b1;
      end
      OP_SHL: begin
        wide      = (r2.a < 16'd32) ? ({16'h0000, r2.b} << r2.a[4:0]) : 32'b0;
        setup.res = wide[15:0];
        setup.exo = wide[31:16];
        setup.wb  = 1'b1;
      end
      OP_IFB: setup.skip = ((r2.a & r2.b) == 16'h0000);
      OP_IFC: setup.skip = ((r2.a & r2.b) != 16'h0000);
      OP_IFE: setup.skip = (r2.a != r2.b);
      OP_IFN: setup.skip = (r2.a == r2.b);
      OP_IFG: setup.skip = ~(r2.b > r2.a);
      OP_IFA: setup.skip = ~($signed(r2.b) > $signed(r2.a));
      OP_IFL: setup.skip = ~(r2.b < r2.a);
      OP_IFU: setup.skip = ~($signed(r2.b) < $signed(r2.a));
      OP_ADX: begin
        wide      = {16'h0000, r2.b} + {16'h0000, r2.a} + {16'h0000, r2.ex};
        setup.res = wide[15:0];
        setup.exo = wide[31:16];
        setup.wb  = 1'b1;
      end
      OP_SBX: begin
        wide      = {16'h0000, r2.b} - {16'h0000, r2.a} + {16'h0000, r2.ex};
        setup.res = wide[15:0];
        setup.exo = wide[31:16];
        setup.wb  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Divider stages, one quotient bit per stage.
  always_comb begin
    for (int k = 1; k <= DIV_BITS; k++) begin
      dnext[k] = div_step(dstg[k-1]);
      if (k == MOD_STEP) begin
        dnext[k].modr = dnext[k].rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_BITS; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= v2;
      for (int k = 1; k <= DIV_BITS; k++) begin
        vd[k] <= vd[k-1];
      end
    end
    if (en) begin
      dstg[0] <= setup;
      for (int k = 1; k <= DIV_BITS; k++) begin
        dstg[k] <= dnext[k];
      end
    end
  end

  // Sign correction and selection of the division results.
  always_comb begin
    fin.res  = dstg[DIV_BITS].res;
    fin.exo  = dstg[DIV_BITS].exo;
    fin.wb   = dstg[DIV_BITS].wb;
    fin.skip = dstg[DIV_BITS].skip;
    fin.step = dstg[DIV_BITS].step;
    unique case (dstg[DIV_BITS].kind)
      OP_DIV, OP_DVI: begin
        if (dstg[DIV_BITS].div0) begin
          fin.res = 16'h0000;
          fin.exo = 16'h0000;
        end else if (dstg[DIV_BITS].neg_q) begin
          fin.res = 16'(-dstg[DIV_BITS].dq[31:16]);
          fin.exo = 16'(-dstg[DIV_BITS].dq[15:0]);
        end else begin
          fin.res = dstg[DIV_BITS].dq[31:16];
          fin.exo = dstg[DIV_BITS].dq[15:0];
        end
      end
      OP_MOD, OP_MDI: begin
        if (dstg[DIV_BITS].div0) begin
          fin.res = 16'h0000;
        end else if (dstg[DIV_BITS].neg_r) begin
          fin.res = 16'(-dstg[DIV_BITS].modr);
        end else begin
          fin.res = dstg[DIV_BITS].modr;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid     <= 1'b0;
      skid_valid <= 1'b0;
    end else if (o_free) begin
      if (skid_valid) begin
        ovalid     <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        ovalid <= vd[DIV_BITS];
      end
    end else if (en && vd[DIV_BITS]) begin
      skid_valid <= 1'b1;
    end
    if (o_free) begin
      obuf <= skid_valid ? skid : fin;
    end else if (en && vd[DIV_BITS]) begin
      skid <= fin;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {4'b0000, obuf.step, obuf.skip, obuf.wb, obuf.exo, obuf.res};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> ovalid)
    else $error("skid register holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(ovalid && !m_tready))
    else $error("skid register filled without an output stall");

  a_no_wb_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !obuf.wb) |-> (obuf.res == 16'h0000 && obuf.step == STEP_NONE))
    else $error("result or index step set on a word without write-back");

  a_wb_skip_excl: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> !(obuf.wb && obuf.skip))
    else $error("write-back and skip both set");
`endif

endmodule
